// ===== sv/rsd_pkg.sv =====
// rsd_pkg: shared constants, register codes and stage payload types of the
// radial spotlight dimmer; no dependencies
package rsd_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int LUMA_BITS      = 16;
    localparam int RAD_BITS       = 15;
    localparam int ROOT_BITS      = 16;
    localparam int SCALE_BITS     = 17;
    localparam int ADDR_BITS      = 3;
    localparam int DATA_BITS      = 32;

    localparam logic [RAD_BITS-1:0]   FAR_DSQ     = 15'd25600;
    localparam logic [SCALE_BITS-1:0] FLOOR_SCALE = 17'd13107;
    localparam logic [SCALE_BITS-1:0] UNITY_SCALE = 17'd65536;
    localparam logic [ROOT_BITS-1:0]  ROOT_LIMIT  = 16'd40960;

    localparam int RECIP_BITS  = 22;
    localparam int RECIP_SHIFT = 26;
    localparam logic [RECIP_BITS-1:0] RECIP_MULT = 22'd2684354;
    localparam logic [5:0]            DIV_BY     = 6'd25;

    typedef enum logic [0:0] {
        REG_CENTER_X = 1'b0,
        REG_CENTER_Y = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [LUMA_BITS-1:0] luma;
        logic                 far;
        logic [RAD_BITS-1:0]  rad;
    } front_out_t;

    typedef struct packed {
        logic [LUMA_BITS-1:0] luma;
        logic                 far;
        logic [ROOT_BITS-1:0] dist8;
    } root_out_t;

endpackage

// ===== sv/rsd_front.sv =====
// rsd_front: three stages of distance work, absolute differences, squares
// and the squared-distance sum with the far test; uses rsd_pkg
module rsd_front #(
    parameter int COORD_BITS = rsd_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [COORD_BITS-1:0]         center_x,
    input  logic [COORD_BITS-1:0]         center_y,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [COORD_BITS-1:0]         pixel_x,
    input  logic [COORD_BITS-1:0]         pixel_y,
    input  logic [rsd_pkg::LUMA_BITS-1:0] luma_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output rsd_pkg::front_out_t           out_data
);
    import rsd_pkg::*;

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int DSQ_W = SQ_W + 1;
    localparam int EXT_W = (DSQ_W > RAD_BITS) ? DSQ_W : RAD_BITS;

    logic [2:0]            valid_reg;
    logic [2:0]            hold;
    logic [COORD_BITS-1:0] dx_reg, dy_reg, dx_next, dy_next;
    logic [LUMA_BITS-1:0]  luma1_reg, luma2_reg;
    logic [SQ_W-1:0]       sqx_reg, sqy_reg, sqx_next, sqy_next;
    logic [EXT_W-1:0]      dsq_next;
    front_out_t            out_reg, out_next;

    assign hold[2] = valid_reg[2] && out_stall;
    assign hold[1] = valid_reg[1] && hold[2];
    assign hold[0] = valid_reg[0] && hold[1];

    always_comb
    begin
        dx_next  = (pixel_x >= center_x) ? pixel_x - center_x : center_x - pixel_x;
        dy_next  = (pixel_y >= center_y) ? pixel_y - center_y : center_y - pixel_y;
        sqx_next = SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_next = SQ_W'(dy_reg) * SQ_W'(dy_reg);
        dsq_next = EXT_W'(sqx_reg) + EXT_W'(sqy_reg);
        out_next.luma = luma2_reg;
        out_next.far  = (dsq_next >= EXT_W'(FAR_DSQ));
        out_next.rad  = dsq_next[RAD_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (!hold[0])
            begin
                valid_reg[0] <= in_valid;
            end
            if (!hold[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
            if (!hold[2])
            begin
                valid_reg[2] <= valid_reg[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold[0])
        begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            luma1_reg <= luma_in;
        end
        if (!hold[1])
        begin
            sqx_reg   <= sqx_next;
            sqy_reg   <= sqy_next;
            luma2_reg <= luma1_reg;
        end
        if (!hold[2])
        begin
            out_reg <= out_next;
        end
    end

    assign in_stall  = hold[0];
    assign out_valid = valid_reg[2];
    assign out_data  = out_reg;

endmodule

// ===== sv/rsd_root.sv =====
// rsd_root: pipelined digit-by-digit integer square root of the squared
// distance with 8 fraction bits, two result bits per stage; uses rsd_pkg
module rsd_root (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  rsd_pkg::front_out_t in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output rsd_pkg::root_out_t  out_data
);
    import rsd_pkg::*;

    localparam int STEPS  = 2;
    localparam int STAGES = ROOT_BITS / STEPS;
    localparam int REM_W  = ROOT_BITS + 3;
    localparam int RADX_W = 2 * ROOT_BITS;
    localparam int FRAC_W = RADX_W - RAD_BITS - 1;

    typedef struct packed {
        logic [REM_W-1:0]     rem;
        logic [ROOT_BITS-1:0] root;
    } step_t;

    function automatic step_t sqrt_step(input logic [REM_W-1:0] rem,
                                        input logic [ROOT_BITS-1:0] root,
                                        input logic [1:0] pair);
        logic [REM_W-1:0] acc;
        logic [REM_W-1:0] trial;
        step_t            s;
        acc   = {rem[REM_W-3:0], pair};
        trial = {1'b0, root, 2'b01};
        if (acc >= trial)
        begin
            s.rem  = acc - trial;
            s.root = {root[ROOT_BITS-2:0], 1'b1};
        end
        else
        begin
            s.rem  = acc;
            s.root = {root[ROOT_BITS-2:0], 1'b0};
        end
        return s;
    endfunction

    logic [STAGES-1:0]    valid_reg;
    logic [STAGES-1:0]    hold;
    logic [REM_W-1:0]     rem_reg  [STAGES];
    logic [ROOT_BITS-1:0] root_reg [STAGES];
    logic [RADX_W-1:0]    bits_reg [STAGES];
    logic [LUMA_BITS-1:0] luma_reg [STAGES];
    logic                 far_reg  [STAGES];

    assign hold[STAGES-1] = valid_reg[STAGES-1] && out_stall;

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        logic [REM_W-1:0]     rem_in;
        logic [ROOT_BITS-1:0] root_in;
        logic [RADX_W-1:0]    bits_in;
        logic [LUMA_BITS-1:0] luma_in;
        logic                 far_in;
        logic                 valid_in;
        step_t                s0, s1;
        logic [RADX_W-1:0]    bits_next;

        if (k == 0)
        begin : g_first
            assign rem_in   = '0;
            assign root_in  = '0;
            assign bits_in  = {1'b0, in_data.rad, {FRAC_W{1'b0}}};
            assign luma_in  = in_data.luma;
            assign far_in   = in_data.far;
            assign valid_in = in_valid;
        end
        else
        begin : g_next
            assign rem_in   = rem_reg[k-1];
            assign root_in  = root_reg[k-1];
            assign bits_in  = bits_reg[k-1];
            assign luma_in  = luma_reg[k-1];
            assign far_in   = far_reg[k-1];
            assign valid_in = valid_reg[k-1];
        end

        if (k < STAGES - 1)
        begin : g_hold
            assign hold[k] = valid_reg[k] && hold[k+1];
        end

        always_comb
        begin
            s0        = sqrt_step(rem_in, root_in, bits_in[RADX_W-1 -: 2]);
            s1        = sqrt_step(s0.rem, s0.root, bits_in[RADX_W-3 -: 2]);
            bits_next = {bits_in[RADX_W-2*STEPS-1:0], {(2*STEPS){1'b0}}};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (!hold[k])
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (!hold[k])
            begin
                rem_reg[k]  <= s1.rem;
                root_reg[k] <= s1.root;
                bits_reg[k] <= bits_next;
                luma_reg[k] <= luma_in;
                far_reg[k]  <= far_in;
            end
        end
    end

    assign in_stall       = hold[0];
    assign out_valid      = valid_reg[STAGES-1];
    assign out_data.luma  = luma_reg[STAGES-1];
    assign out_data.far   = far_reg[STAGES-1];
    assign out_data.dist8 = root_reg[STAGES-1];

endmodule

// ===== sv/rsd_scale.sv =====
// rsd_scale: three stages that turn the distance into a Q1.16 gain through a
// reciprocal multiply by 1/25 and apply it to the luminance; uses rsd_pkg
module rsd_scale (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  rsd_pkg::root_out_t            in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rsd_pkg::LUMA_BITS-1:0] luma_out
);
    import rsd_pkg::*;

    localparam int NUM_W  = ROOT_BITS + 5;
    localparam int PROD_W = NUM_W + RECIP_BITS;
    localparam int Q_W    = PROD_W - RECIP_SHIFT;
    localparam int MUL_W  = LUMA_BITS + SCALE_BITS;

    logic [2:0]            valid_reg;
    logic [2:0]            hold;
    logic [NUM_W-1:0]      num_reg, num_next;
    logic [PROD_W-1:0]     prod_next;
    logic [Q_W-1:0]        q0_reg, q0_next, q_next;
    logic [NUM_W-1:0]      rem_next;
    logic [LUMA_BITS-1:0]  luma_a_reg, luma_b_reg, luma_out_reg, luma_out_next;
    logic                  far_a_reg;
    logic [SCALE_BITS-1:0] scale_reg, scale_next;
    logic [MUL_W-1:0]      mul_next;

    assign hold[2] = valid_reg[2] && out_stall;
    assign hold[1] = valid_reg[1] && hold[2];
    assign hold[0] = valid_reg[0] && hold[1];

    always_comb
    begin
        num_next  = {in_data.dist8, 5'b0};
        prod_next = PROD_W'(num_next) * PROD_W'(RECIP_MULT);
        q0_next   = prod_next[PROD_W-1:RECIP_SHIFT];
        rem_next  = num_reg - NUM_W'(NUM_W'(q0_reg) * NUM_W'(DIV_BY));
        q_next    = q0_reg + Q_W'(rem_next >= NUM_W'(DIV_BY));
        scale_next = far_a_reg ? FLOOR_SCALE : UNITY_SCALE - SCALE_BITS'(q_next);
        mul_next  = MUL_W'(luma_b_reg) * MUL_W'(scale_reg);
        luma_out_next = mul_next[2*LUMA_BITS-1:LUMA_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (!hold[0])
            begin
                valid_reg[0] <= in_valid;
            end
            if (!hold[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
            if (!hold[2])
            begin
                valid_reg[2] <= valid_reg[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold[0])
        begin
            num_reg    <= num_next;
            q0_reg     <= q0_next;
            luma_a_reg <= in_data.luma;
            far_a_reg  <= in_data.far;
        end
        if (!hold[1])
        begin
            scale_reg  <= scale_next;
            luma_b_reg <= luma_a_reg;
        end
        if (!hold[2])
        begin
            luma_out_reg <= luma_out_next;
        end
    end

    assign in_stall  = hold[0];
    assign out_valid = valid_reg[2];
    assign luma_out  = luma_out_reg;

endmodule

// ===== sv/radial_spotlight_dimmer.sv =====
// radial_spotlight_dimmer: top level, APB center registers and the chain of
// distance, square-root and gain pipelines; uses rsd_pkg, rsd_front,
// rsd_root and rsd_scale
//
// Linear radial vignette on a luminance stream: each item (column, row,
// luminance) leaves with its luminance scaled by 1 - 0.005 per pixel of
// distance from the center, never below 0.2 beyond 160 pixels. One item
// enters per clock while in_stall is low and passes 3 distance stages,
// 8 square-root stages of two root bits each and 3 gain stages.
// Stalls hold only the stages that are full, so bubbles close up. The
// center registers are written over APB at 0x0 (x) and 0x4 (y).
module radial_spotlight_dimmer #(
    parameter int COORD_BITS = rsd_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rsd_pkg::ADDR_BITS-1:0] paddr,
    input  logic [rsd_pkg::DATA_BITS-1:0] pwdata,
    output logic [rsd_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [COORD_BITS-1:0]         pixel_x,
    input  logic [COORD_BITS-1:0]         pixel_y,
    input  logic [rsd_pkg::LUMA_BITS-1:0] luma_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rsd_pkg::LUMA_BITS-1:0] luma_out
);
    import rsd_pkg::*;

    logic [COORD_BITS-1:0] center_x_reg, center_y_reg;
    logic                  wr_en;
    reg_idx_t              reg_idx;
    logic                  front_valid, front_stall;
    front_out_t            front_data;
    logic                  root_valid, root_stall;
    root_out_t             root_data;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_CENTER_X: center_x_reg <= pwdata[COORD_BITS-1:0];
                REG_CENTER_Y: center_y_reg <= pwdata[COORD_BITS-1:0];
                default:      center_x_reg <= center_x_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_CENTER_X: prdata = DATA_BITS'(center_x_reg);
            REG_CENTER_Y: prdata = DATA_BITS'(center_y_reg);
            default:      prdata = '0;
        endcase
    end

    rsd_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .luma_in   (luma_in),
        .out_valid (front_valid),
        .out_stall (front_stall),
        .out_data  (front_data)
    );

    rsd_root u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_stall  (front_stall),
        .in_data   (front_data),
        .out_valid (root_valid),
        .out_stall (root_stall),
        .out_data  (root_data)
    );

    rsd_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (root_valid),
        .in_stall  (root_stall),
        .in_data   (root_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .luma_out  (luma_out)
    );

    // input is held back only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a stalled result");

    // a near pixel has a root below 160 pixels
    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        (root_valid && !root_data.far) |-> (root_data.dist8 < ROOT_LIMIT))
        else $error("root out of range for a near pixel");

    // a write to center_x reaches the center_x register
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && reg_idx == REG_CENTER_X) |=>
        (center_x_reg == $past(pwdata[COORD_BITS-1:0])))
        else $error("center_x write lost");

endmodule
